// ----- rtl/core/assert_macros.svh -----
// Assertion macros shared by the convexity check RTL.
// Depends on nothing; included by the modules that carry assertions.
// With SYNTHESIS defined the macros expand to nothing.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// The property must hold at every rising edge outside reset.
`define PCC_ASSERT(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("pcc assertion failed");

// The expression must never be true at a rising edge outside reset.
`define PCC_ASSERT_NEVER(label, clk, rst_n, expr) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
        else $error("pcc forbidden condition seen");

`else

`define PCC_ASSERT(label, clk, rst_n, prop)

`define PCC_ASSERT_NEVER(label, clk, rst_n, expr)

`endif

`endif

// ----- rtl/core/pcc_pkg.sv -----
// Package for the polygon convexity check: widths, sign codes and the job word.
// Depends on nothing; used by every module of the block.
package pcc_pkg;

    // Coordinate width used for the arithmetic and the port width of a coordinate.
    localparam int COORD_WIDTH = 16;
    localparam int IN_WIDTH    = 16;

    // A difference of two coordinates, a product of two differences, a difference of products.
    localparam int DIFF_W = COORD_WIDTH + 1;
    localparam int PROD_W = 2 * DIFF_W;
    localparam int DET_W  = PROD_W + 1;

    // Turns that one vertex can cause: its own, and the two that wrap on the last vertex.
    localparam int NUM_TURNS = 3;

    // Job queue between the front and back halves.
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = QPTR_W + 1;

    typedef logic signed [COORD_WIDTH-1:0] t_coord;
    typedef logic signed [DIFF_W-1:0]      t_diff;
    typedef logic signed [PROD_W-1:0]      t_prod;
    typedef logic signed [DET_W-1:0]       t_det;

    // Turn sign codes.
    typedef logic [1:0] t_sign;
    localparam t_sign SIGN_NONE = 2'd0;
    localparam t_sign SIGN_POS  = 2'd1;
    localparam t_sign SIGN_NEG  = 2'd2;

    // Vertex count, saturating at three.
    typedef logic [1:0] t_vcount;
    localparam t_vcount VCOUNT_ZERO = 2'd0;
    localparam t_vcount VCOUNT_ONE  = 2'd1;
    localparam t_vcount VCOUNT_PAIR = 2'd2;
    localparam t_vcount VCOUNT_SAT  = 2'd3;

    typedef struct packed {
        t_coord x;
        t_coord y;
    } t_point;

    // Operands of one turn: sign of bx * cy - by * cx.
    typedef struct packed {
        t_diff bx;
        t_diff cy;
        t_diff by;
        t_diff cx;
    } t_turn;

    // One queued job: the turns a vertex causes and how the polygon ends.
    typedef struct packed {
        t_turn [NUM_TURNS-1:0] turns;
        logic  [NUM_TURNS-1:0] turn_valid;
        logic                  last;
        logic                  rejected;
    } t_job;

    // Low COORD_WIDTH bits of a raw coordinate, read as two's complement.
    function automatic t_coord to_coord(input logic [IN_WIDTH-1:0] raw);
        logic [COORD_WIDTH+IN_WIDTH-1:0] ext;
        ext = {{COORD_WIDTH{1'b0}}, raw};
        return $signed(ext[COORD_WIDTH-1:0]);
    endfunction

endpackage

// ----- rtl/core/pcc_queue.sv -----
// Short job queue that decouples the vertex front end from the turn arithmetic.
// Depends on pcc_pkg and assert_macros.svh.
`include "assert_macros.svh"

module pcc_queue (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  pcc_pkg::t_job i_push_job,
    output logic          o_full,
    input  logic          i_pop,
    output logic          o_empty,
    output pcc_pkg::t_job o_job
);

    localparam logic [pcc_pkg::QCNT_W-1:0] QCNT_FULL = pcc_pkg::QCNT_W'(pcc_pkg::QUEUE_DEPTH);
    localparam logic [pcc_pkg::QPTR_W-1:0] QPTR_ONE  = pcc_pkg::QPTR_W'(1);
    localparam logic [pcc_pkg::QCNT_W-1:0] QCNT_ONE  = pcc_pkg::QCNT_W'(1);

    pcc_pkg::t_job                r_mem [pcc_pkg::QUEUE_DEPTH];
    logic [pcc_pkg::QPTR_W-1:0]   r_wr_ptr;
    logic [pcc_pkg::QPTR_W-1:0]   r_rd_ptr;
    logic [pcc_pkg::QCNT_W-1:0]   r_count;
    logic [pcc_pkg::QCNT_W-1:0]   n_count;
    logic                         push_ok;
    logic                         pop_ok;

    assign o_full  = (r_count == QCNT_FULL);
    assign o_empty = (r_count == '0);
    assign o_job   = r_mem[r_rd_ptr];
    assign push_ok = i_push && !o_full;
    assign pop_ok  = i_pop && !o_empty;

    // Occupancy follows pushes and pops.
    always_comb begin
        n_count = r_count;
        if (push_ok && !pop_ok) begin
            n_count = r_count + QCNT_ONE;
        end else if (pop_ok && !push_ok) begin
            n_count = r_count - QCNT_ONE;
        end
    end

    // Pointers and count.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_count <= n_count;
            if (push_ok) begin
                r_wr_ptr <= r_wr_ptr + QPTR_ONE;
            end
            if (pop_ok) begin
                r_rd_ptr <= r_rd_ptr + QPTR_ONE;
            end
        end
    end

    // Storage for queued words.
    always_ff @(posedge i_clk) begin
        if (push_ok) begin
            r_mem[r_wr_ptr] <= i_push_job;
        end
    end

    `PCC_ASSERT_NEVER(a_no_push_when_full, i_clk, i_rst_n, i_push && o_full)

endmodule

// ----- rtl/core/pcc_front.sv -----
// Front end of the convexity check: accepts vertices, keeps the vertex history
// and turns each vertex into a job of coordinate differences. Depends on pcc_pkg.
`include "assert_macros.svh"

module pcc_front (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_valid,
    output logic                             o_stall,
    input  logic signed [pcc_pkg::IN_WIDTH-1:0] i_vertex_x,
    input  logic signed [pcc_pkg::IN_WIDTH-1:0] i_vertex_y,
    input  logic                             i_last_vertex,
    input  logic                             i_polygon_closed,
    input  logic                             i_queue_full,
    output logic                             o_push,
    output pcc_pkg::t_job                    o_job
);

    pcc_pkg::t_point   r_first;
    pcc_pkg::t_point   r_second;
    pcc_pkg::t_point   r_older;
    pcc_pkg::t_point   r_newer;
    pcc_pkg::t_vcount  r_count;
    pcc_pkg::t_vcount  n_count;
    pcc_pkg::t_point   cur;
    logic              accept;
    logic              took_last;
    logic              enough;
    logic              wrap_ok;

    // Operands of the turn through a, b and c.
    function automatic pcc_pkg::t_turn make_turn(input pcc_pkg::t_point a,
                                                 input pcc_pkg::t_point b,
                                                 input pcc_pkg::t_point c);
        pcc_pkg::t_turn t;
        t.bx = pcc_pkg::t_diff'(b.x) - pcc_pkg::t_diff'(a.x);
        t.cy = pcc_pkg::t_diff'(c.y) - pcc_pkg::t_diff'(a.y);
        t.by = pcc_pkg::t_diff'(b.y) - pcc_pkg::t_diff'(a.y);
        t.cx = pcc_pkg::t_diff'(c.x) - pcc_pkg::t_diff'(a.x);
        return t;
    endfunction

    // A word is taken whenever the queue has room; nothing is taken during reset.
    assign o_stall   = i_queue_full || !i_rst_n;
    assign accept    = i_valid && !o_stall;
    assign o_push    = accept;
    assign took_last = accept && i_last_vertex;

    assign cur.x   = pcc_pkg::to_coord(i_vertex_x);
    assign cur.y   = pcc_pkg::to_coord(i_vertex_y);
    assign enough  = (r_count >= pcc_pkg::VCOUNT_PAIR);
    assign wrap_ok = enough && i_last_vertex && i_polygon_closed;

    // Build the job: own turn, then the two wrap-around turns on a closed last vertex.
    always_comb begin
        o_job.turns[0]      = make_turn(r_older, r_newer, cur);
        o_job.turns[1]      = make_turn(r_newer, cur, r_first);
        o_job.turns[2]      = make_turn(cur, r_first, r_second);
        o_job.turn_valid[0] = enough;
        o_job.turn_valid[1] = wrap_ok;
        o_job.turn_valid[2] = wrap_ok;
        o_job.last          = i_last_vertex;
        o_job.rejected      = !(enough && i_polygon_closed);
    end

    // Vertex count: saturates at three and clears after the last vertex.
    always_comb begin
        n_count = r_count;
        if (accept) begin
            if (i_last_vertex) begin
                n_count = pcc_pkg::VCOUNT_ZERO;
            end else if (r_count != pcc_pkg::VCOUNT_SAT) begin
                n_count = r_count + pcc_pkg::VCOUNT_ONE;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= pcc_pkg::VCOUNT_ZERO;
        end else begin
            r_count <= n_count;
        end
    end

    // Vertex history: the first two vertices and the two most recent ones.
    always_ff @(posedge i_clk) begin
        if (accept) begin
            if (r_count == pcc_pkg::VCOUNT_ZERO) begin
                r_first <= cur;
            end
            if (r_count == pcc_pkg::VCOUNT_ONE) begin
                r_second <= cur;
            end
            if (!i_last_vertex) begin
                r_older <= r_newer;
                r_newer <= cur;
            end
        end
    end

    `PCC_ASSERT(a_count_clears, i_clk, i_rst_n, took_last |=> r_count == pcc_pkg::VCOUNT_ZERO)

endmodule

// ----- rtl/core/pcc_back.sv -----
// Back end of the convexity check: multiplies, resolves turn signs, tracks the
// reference sign and holds the result word. Depends on pcc_pkg.
`include "assert_macros.svh"

module pcc_back (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_empty,
    input  pcc_pkg::t_job i_job,
    output logic          o_pop,
    output logic          o_valid,
    input  logic          i_stall,
    output logic          o_convex,
    output logic          o_rejected
);

    logic                               adv;
    // Product stage.
    logic                               r_s1_valid;
    pcc_pkg::t_prod                     r_p [pcc_pkg::NUM_TURNS];
    pcc_pkg::t_prod                     r_q [pcc_pkg::NUM_TURNS];
    logic [pcc_pkg::NUM_TURNS-1:0]      r_s1_turn_valid;
    logic                               r_s1_last;
    logic                               r_s1_rejected;
    // Sign stage.
    pcc_pkg::t_det                      s1_det [pcc_pkg::NUM_TURNS];
    pcc_pkg::t_sign                     s1_sign [pcc_pkg::NUM_TURNS];
    logic                               r_s2_valid;
    pcc_pkg::t_sign                     r_s2_sign [pcc_pkg::NUM_TURNS];
    logic                               r_s2_last;
    logic                               r_s2_rejected;
    // Reference sign tracking and result.
    pcc_pkg::t_sign                     r_ref;
    logic                               r_conflict;
    pcc_pkg::t_sign                     fold_ref;
    logic                               fold_conflict;
    pcc_pkg::t_sign                     n_ref;
    logic                               n_conflict;
    logic                               r_out_valid;
    logic                               r_convex;
    logic                               r_rejected;

    // The whole back pipeline moves unless a result word is held up.
    assign adv   = !r_out_valid || !i_stall;
    assign o_pop = adv && !i_empty;

    assign o_valid    = r_out_valid;
    assign o_convex   = r_convex;
    assign o_rejected = r_rejected;

    // Sign of each cross product difference; a turn that does not apply counts as zero.
    always_comb begin
        for (int k = 0; k < pcc_pkg::NUM_TURNS; k++) begin
            s1_det[k] = pcc_pkg::t_det'(r_p[k]) - pcc_pkg::t_det'(r_q[k]);
            if (!r_s1_turn_valid[k] || (s1_det[k] == '0)) begin
                s1_sign[k] = pcc_pkg::SIGN_NONE;
            end else if (s1_det[k][pcc_pkg::DET_W-1]) begin
                s1_sign[k] = pcc_pkg::SIGN_NEG;
            end else begin
                s1_sign[k] = pcc_pkg::SIGN_POS;
            end
        end
    end

    // Apply the turns in order: the first nonzero one sets the reference sign.
    always_comb begin
        fold_ref      = r_ref;
        fold_conflict = r_conflict;
        for (int k = 0; k < pcc_pkg::NUM_TURNS; k++) begin
            if (r_s2_sign[k] != pcc_pkg::SIGN_NONE) begin
                if (fold_ref == pcc_pkg::SIGN_NONE) begin
                    fold_ref = r_s2_sign[k];
                end else if (fold_ref != r_s2_sign[k]) begin
                    fold_conflict = 1'b1;
                end
            end
        end
        if (r_s2_last) begin
            n_ref      = pcc_pkg::SIGN_NONE;
            n_conflict = 1'b0;
        end else begin
            n_ref      = fold_ref;
            n_conflict = fold_conflict;
        end
    end

    // Control: stage valids, result valid and the per-polygon sign state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_s2_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_ref       <= pcc_pkg::SIGN_NONE;
            r_conflict  <= 1'b0;
        end else if (adv) begin
            r_s1_valid  <= o_pop;
            r_s2_valid  <= r_s1_valid;
            r_out_valid <= r_s2_valid && r_s2_last;
            if (r_s2_valid) begin
                r_ref      <= n_ref;
                r_conflict <= n_conflict;
            end
        end
    end

    // Data path registers.
    always_ff @(posedge i_clk) begin
        if (adv) begin
            for (int k = 0; k < pcc_pkg::NUM_TURNS; k++) begin
                r_p[k]       <= pcc_pkg::t_prod'(i_job.turns[k].bx)
                              * pcc_pkg::t_prod'(i_job.turns[k].cy);
                r_q[k]       <= pcc_pkg::t_prod'(i_job.turns[k].by)
                              * pcc_pkg::t_prod'(i_job.turns[k].cx);
                r_s2_sign[k] <= s1_sign[k];
            end
            r_s1_turn_valid <= i_job.turn_valid;
            r_s1_last       <= i_job.last;
            r_s1_rejected   <= i_job.rejected;
            r_s2_last       <= r_s1_last;
            r_s2_rejected   <= r_s1_rejected;
            r_convex        <= !r_s2_rejected && !fold_conflict;
            r_rejected      <= r_s2_rejected;
        end
    end

    `PCC_ASSERT_NEVER(a_rejected_not_convex, i_clk, i_rst_n, r_out_valid && r_rejected && r_convex)
    `PCC_ASSERT(a_state_clears_on_last, i_clk, i_rst_n, adv && r_s2_valid && r_s2_last |=> r_ref == pcc_pkg::SIGN_NONE && !r_conflict)

endmodule

// ----- rtl/core/polygon_convexity_check_unit.sv -----
// Top level of the polygon convexity check.
// Depends on pcc_pkg, pcc_front, pcc_queue and pcc_back.
//
// Vertices of a polygon stream in one word per cycle while o_stall is low, each
// with a last-vertex mark and, on the last one, a closed flag. Every turn of
// three consecutive vertices, the two that wrap round to the start included, is
// checked for its cross product sign; the first nonzero turn sets the reference
// and a nonzero turn of the other sign makes the polygon not convex. One result
// word per polygon follows its last vertex through the queue, the product and
// sign stages and the output register. A new vertex can be taken every cycle
// while the queue has room: the front end writes a job into a four-word queue,
// and the back end runs two multiplier and sign stages and an output register
// at one job per cycle, so the sustained rate is set by that single pipeline
// and a stalled output stops only the back end until the queue fills.
module polygon_convexity_check_unit (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_valid,
    output logic                                o_stall,
    input  logic signed [pcc_pkg::IN_WIDTH-1:0] i_vertex_x,
    input  logic signed [pcc_pkg::IN_WIDTH-1:0] i_vertex_y,
    input  logic                                i_last_vertex,
    input  logic                                i_polygon_closed,
    output logic                                o_valid,
    input  logic                                i_stall,
    output logic                                o_convex,
    output logic                                o_rejected
);

    logic          push;
    logic          pop;
    logic          full;
    logic          empty;
    pcc_pkg::t_job push_job;
    pcc_pkg::t_job pop_job;

    // Vertex intake and job building.
    pcc_front u_front (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_valid          (i_valid),
        .o_stall          (o_stall),
        .i_vertex_x       (i_vertex_x),
        .i_vertex_y       (i_vertex_y),
        .i_last_vertex    (i_last_vertex),
        .i_polygon_closed (i_polygon_closed),
        .i_queue_full     (full),
        .o_push           (push),
        .o_job            (push_job)
    );

    // Job queue between the two halves.
    pcc_queue u_queue (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push     (push),
        .i_push_job (push_job),
        .o_full     (full),
        .i_pop      (pop),
        .o_empty    (empty),
        .o_job      (pop_job)
    );

    // Turn arithmetic and result.
    pcc_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_empty    (empty),
        .i_job      (pop_job),
        .o_pop      (pop),
        .o_valid    (o_valid),
        .i_stall    (i_stall),
        .o_convex   (o_convex),
        .o_rejected (o_rejected)
    );

endmodule
